[hw/rtl/rcl_pkg.sv]
// Shared constants and types for the record cell locator.
package rcl_pkg;

   localparam int MAX_RECORD_BYTES_DEF = 65535;

   localparam int BYTE_W   = 8;
   localparam int OFFSET_W = 16;
   localparam int END_W    = 17;
   localparam int COLUMN_W = 16;
   localparam int COUNT_W  = 14;
   localparam int HDR_W    = 24;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [END_W-1:0]   CELLS_START = END_W'(2);
   localparam logic [END_W-1:0]   HEADER_LEN  = END_W'(4);
   localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(16383);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_TARGET_COLUMN = 2'd0,
      REG_TARGET_INDEX  = 2'd1
   } reg_index_type;

   typedef enum logic [1:0] {
      HDR_ID_LO  = 2'd0,
      HDR_ID_HI  = 2'd1,
      HDR_LEN_LO = 2'd2,
      HDR_LEN_HI = 2'd3
   } hdr_pos_type;

endpackage

[hw/rtl/rcl_if.sv]
// Channel interfaces: record bytes in, locator results out, register writes.
interface rcl_req_if;
   logic                        valid;
   logic                        ready;
   logic [rcl_pkg::BYTE_W-1:0]  data_byte;
   logic                        last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rcl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rcl_pkg::OFFSET_W-1:0]  cell_offset;
   logic [rcl_pkg::COUNT_W-1:0]   cell_count;
   logic [rcl_pkg::COLUMN_W-1:0]  indexed_column;
   logic                          corrupt;

   modport source (output valid, output cell_offset, output cell_count,
                   output indexed_column, output corrupt, input ready);
   modport sink   (input valid, input cell_offset, input cell_count,
                   input indexed_column, input corrupt, output ready);
endinterface

interface rcl_csr_if;
   logic                             valid;
   logic                             ready;
   logic [rcl_pkg::CSR_INDEX_W-1:0]  index;
   logic [rcl_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/record_cell_locator.sv]
// Record cell locator: follows cell headers in a byte stream and reports one result per record.
//
// Takes one record byte per cycle with no gaps of its own; each accepted byte is
// registered and then processed in the following cycle unless stalled as below, so
// a record's last byte passes the input register, then the result register.  The
// per-byte path, a 17-bit add of the cell length to the header position followed
// by the end-of-record compare, sets the clock rate.  A pending result that is not
// taken stalls only the last byte of the next record; the bytes before it keep
// flowing.  Register writes are always accepted and must be made while no record is in flight.
module record_cell_locator #(
   parameter int MAX_RECORD_BYTES = rcl_pkg::MAX_RECORD_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   rcl_req_if.sink     req_chan,
   rcl_rsp_if.source   rsp_chan,
   rcl_csr_if.sink     csr_chan
);

   localparam logic [rcl_pkg::OFFSET_W-1:0] OFFSET_LIMIT = rcl_pkg::OFFSET_W'(MAX_RECORD_BYTES);

   // configuration
   logic [rcl_pkg::COLUMN_W-1:0] target_column_ff;
   logic [rcl_pkg::COUNT_W-1:0]  target_index_ff;

   // input register
   logic                        in_valid_ff;
   logic [rcl_pkg::BYTE_W-1:0]  in_byte_ff;
   logic                        in_last_ff;

   // per-record state
   logic [rcl_pkg::OFFSET_W-1:0] byte_offset_ff, byte_offset_in;
   logic [rcl_pkg::HDR_W-1:0]    header_ff, header_in;
   logic [rcl_pkg::END_W-1:0]    cell_end_ff, cell_end_in;
   logic [rcl_pkg::END_W-1:0]    pending_ff, pending_in;
   logic [rcl_pkg::OFFSET_W-1:0] found_ff, found_in;
   logic                         done_ff, done_in;
   logic [rcl_pkg::COUNT_W-1:0]  cells_ff, cells_in;
   logic [rcl_pkg::COLUMN_W-1:0] index_col_ff, index_col_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rcl_pkg::OFFSET_W-1:0]  rsp_offset_ff;
   logic [rcl_pkg::COUNT_W-1:0]   rsp_count_ff;
   logic [rcl_pkg::COLUMN_W-1:0]  rsp_column_ff;
   logic                          rsp_corrupt_ff;

   logic                          advance, process;
   logic                          take, in_hdr;
   logic [rcl_pkg::END_W-1:0]     offset_ext, hdr_diff, next_end;
   logic [rcl_pkg::COLUMN_W-1:0]  hdr_id;
   logic [rcl_pkg::COLUMN_W-1:0]  hdr_len;
   logic [rcl_pkg::OFFSET_W-1:0]  res_offset;
   logic                          res_bad;

   // a last byte may only go through once the result register can take its result
   assign advance        = !(in_last_ff && rsp_valid_ff && !rsp_chan.ready);
   assign process        = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.cell_offset    = rsp_offset_ff;
   assign rsp_chan.cell_count     = rsp_count_ff;
   assign rsp_chan.indexed_column = rsp_column_ff;
   assign rsp_chan.corrupt        = rsp_corrupt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_column_ff <= '0;
         target_index_ff  <= '0;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            rcl_pkg::REG_TARGET_COLUMN: target_column_ff <= csr_chan.data;
            rcl_pkg::REG_TARGET_INDEX:  target_index_ff  <= csr_chan.data[rcl_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.data_byte;
         in_last_ff <= req_chan.last_byte;
      end
   end

   always_comb begin
      take       = byte_offset_ff < OFFSET_LIMIT;
      offset_ext = {1'b0, byte_offset_ff};
      hdr_diff   = offset_ext - cell_end_ff;
      in_hdr     = take && (offset_ext >= cell_end_ff) && (hdr_diff < rcl_pkg::HEADER_LEN);
      hdr_id     = header_ff[15:0];
      hdr_len    = {in_byte_ff, header_ff[23:16]};
      next_end   = cell_end_ff + rcl_pkg::END_W'(hdr_len) + rcl_pkg::HEADER_LEN;

      byte_offset_in = take ? byte_offset_ff + 1'b1 : byte_offset_ff;
      header_in      = header_ff;
      cell_end_in    = cell_end_ff;
      pending_in     = pending_ff;
      found_in       = found_ff;
      done_in        = done_ff;
      cells_in       = cells_ff;
      index_col_in   = index_col_ff;

      if (in_hdr) begin
         case (hdr_diff[1:0])
            rcl_pkg::HDR_ID_LO:  header_in[7:0]   = in_byte_ff;
            rcl_pkg::HDR_ID_HI:  header_in[15:8]  = in_byte_ff;
            rcl_pkg::HDR_LEN_LO: header_in[23:16] = in_byte_ff;
            rcl_pkg::HDR_LEN_HI: begin
               if (cells_ff < rcl_pkg::COUNT_MAX) begin
                  if (cells_ff == target_index_ff)
                     index_col_in = hdr_id;
                  cells_in = cells_ff + 1'b1;
               end
               if (!done_ff && hdr_id == target_column_ff) begin
                  done_in    = 1'b1;
                  found_in   = cell_end_ff[rcl_pkg::OFFSET_W-1:0];
                  pending_in = next_end;
               end
               cell_end_in = next_end;
            end
            default: ;
         endcase
      end

      // record length is the updated byte count
      res_offset = '0;
      res_bad    = 1'b0;
      if (done_in) begin
         if (pending_in > {1'b0, byte_offset_in})
            res_bad = 1'b1;
         else
            res_offset = found_in;
      end else if (cells_in != '0 && cell_end_in > {1'b0, byte_offset_in}) begin
         res_bad = 1'b1;
      end

      rsp_valid_in = (rsp_valid_ff && !rsp_chan.ready) || (process && in_last_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_offset_ff <= '0;
         cell_end_ff    <= rcl_pkg::CELLS_START;
         pending_ff     <= '0;
         found_ff       <= '0;
         done_ff        <= 1'b0;
         cells_ff       <= '0;
         index_col_ff   <= '0;
      end else if (process) begin
         if (in_last_ff) begin
            byte_offset_ff <= '0;
            cell_end_ff    <= rcl_pkg::CELLS_START;
            pending_ff     <= '0;
            found_ff       <= '0;
            done_ff        <= 1'b0;
            cells_ff       <= '0;
            index_col_ff   <= '0;
         end else begin
            byte_offset_ff <= byte_offset_in;
            cell_end_ff    <= cell_end_in;
            pending_ff     <= pending_in;
            found_ff       <= found_in;
            done_ff        <= done_in;
            cells_ff       <= cells_in;
            index_col_ff   <= index_col_in;
         end
      end
   end

   // header bytes are rewritten lane by lane before use, so no reset needed
   always_ff @(posedge clock) begin
      if (process)
         header_ff <= header_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (process && in_last_ff) begin
         rsp_offset_ff  <= res_offset;
         rsp_count_ff   <= cells_in;
         rsp_column_ff  <= index_col_in;
         rsp_corrupt_ff <= res_bad;
      end
   end

endmodule
